/* design/occ_grid_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// occ_grid_pkg
// Shared constants, codes and control/status types of the grid cell engine.
// ============================================================================
package occ_grid_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int ADDR_W    = COL_AW + ROW_AW;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    localparam int CELL_W  = 3;
    localparam int CMD_W   = 4;
    localparam int POS_W   = 7;
    localparam int CFG_W   = 7;
    localparam int ACT_W   = CFG_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int STAT_W  = 2;
    localparam int VER_W   = 32;

    localparam logic [COL_AW-1:0] COL_LAST = COL_AW'(MAX_COLS - 1);
    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(MAX_ROWS - 1);
    localparam logic [ACT_W-1:0]  ACT_COLS_MAX = ACT_W'(MAX_COLS);
    localparam logic [ACT_W-1:0]  ACT_ROWS_MAX = ACT_W'(MAX_ROWS);

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;
    localparam logic [CFG_W-1:0]     COLS_RST = 7'd12;
    localparam logic [CFG_W-1:0]     ROWS_RST = 7'd10;

    localparam logic [CMD_W-1:0] CMD_QUERY    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_ST   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_RM_ST    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ADD_VIRT = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RM_VIRT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ADD_MOV  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_RM_MOV   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CLR_OBS  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_CLR_MOV  = 4'd10;

    localparam logic [CELL_W-1:0] CS_FREE    = 3'd0;
    localparam logic [CELL_W-1:0] CS_DELETED = 3'd1;
    localparam logic [CELL_W-1:0] CS_STATIC  = 3'd2;
    localparam logic [CELL_W-1:0] CS_DYNAMIC = 3'd3;
    localparam logic [CELL_W-1:0] CS_BOTH    = 3'd4;
    localparam logic [CELL_W-1:0] CS_VIRTUAL = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_ERR  = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGN  = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_in;
        logic rd_walk;
        logic rd_tgt;
        logic init_wr;
        logic walk_wr;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic in_clear;
        logic grid_empty;
        logic walk_last;
    } t_sts;

endpackage

/* design/occ_grid_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// occ_grid_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module occ_grid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/occ_grid_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// occ_grid_ctrl
// Sequencer: reset clearing pass, single-cell read-modify-write, grid walk.
// ============================================================================
module occ_grid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  occ_grid_pkg::t_sts i_sts,
    output occ_grid_pkg::t_ctl o_ctl
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WRD  = 3'd2;
    localparam logic [2:0] S_WWR  = 3'd3;
    localparam logic [2:0] S_TRD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_INIT: begin
                o_ctl.init_wr = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ctl.rd_in = 1'b1;
                if (start) begin
                    o_ctl.load = 1'b1;
                    if (!i_sts.in_clear) begin
                        n_state = S_FIN;
                    end else if (i_sts.grid_empty) begin
                        n_state = S_TRD;
                    end else begin
                        n_state = S_WRD;
                    end
                end
            end
            S_WRD: begin
                o_ctl.rd_walk = 1'b1;
                n_state = S_WWR;
            end
            S_WWR: begin
                o_ctl.walk_wr = 1'b1;
                n_state = i_sts.walk_last ? S_TRD : S_WRD;
            end
            S_TRD: begin
                o_ctl.rd_tgt = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_ctl.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* design/occ_grid_dp.sv */
`timescale 1ns / 1ps
// ============================================================================
// occ_grid_dp
// Datapath: grid size registers, walk counters, cell RAM, update rules,
// change counter and result registers.
// ============================================================================
module occ_grid_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  occ_grid_pkg::t_ctl                  i_ctl,
    output occ_grid_pkg::t_sts                  o_sts,
    input  logic                                i_cfg_we,
    input  logic [occ_grid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [occ_grid_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [occ_grid_pkg::CMD_W-1:0]      i_command,
    input  logic [occ_grid_pkg::POS_W-1:0]      i_col,
    input  logic [occ_grid_pkg::POS_W-1:0]      i_row,
    output logic                                o_valid,
    output logic [occ_grid_pkg::STAT_W-1:0]     o_status,
    output logic [occ_grid_pkg::CELL_W-1:0]     o_cell_state,
    output logic                                o_is_free,
    output logic [occ_grid_pkg::VER_W-1:0]      o_change_count
);

    logic [occ_grid_pkg::CFG_W-1:0]  r_cols, r_rows;
    logic [occ_grid_pkg::ACT_W-1:0]  act_cols, act_rows;
    logic [occ_grid_pkg::COL_AW-1:0] r_wc, lim_c, walk_c_last;
    logic [occ_grid_pkg::ROW_AW-1:0] r_wr, lim_r, walk_r_last;
    logic                            row_last;

    logic [occ_grid_pkg::CMD_W-1:0]  r_cmd;
    logic [occ_grid_pkg::COL_AW-1:0] r_tc;
    logic [occ_grid_pkg::ROW_AW-1:0] r_tr;
    logic                            r_tvalid;
    logic                            in_valid;

    logic [occ_grid_pkg::VER_W-1:0]  r_version, n_version;
    logic                            r_out_vld;
    logic [occ_grid_pkg::STAT_W-1:0] r_status, n_status;
    logic [occ_grid_pkg::CELL_W-1:0] r_cell, n_cell;
    logic                            r_free;

    logic                            ram_we, ram_re;
    logic [occ_grid_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [occ_grid_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
    logic [occ_grid_pkg::ADDR_W-1:0] in_addr, walk_addr, tgt_addr;

    logic [occ_grid_pkg::CELL_W-1:0] cleared, nv;
    logic                            chg, is_clear;

    // grid size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= occ_grid_pkg::COLS_RST;
            r_rows <= occ_grid_pkg::ROWS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == occ_grid_pkg::CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
            if (i_cfg_idx == occ_grid_pkg::CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
        end
    end

    assign act_cols = ({1'b0, r_cols} > occ_grid_pkg::ACT_COLS_MAX) ?
                      occ_grid_pkg::ACT_COLS_MAX : {1'b0, r_cols};
    assign act_rows = ({1'b0, r_rows} > occ_grid_pkg::ACT_ROWS_MAX) ?
                      occ_grid_pkg::ACT_ROWS_MAX : {1'b0, r_rows};

    assign in_valid = ({1'b0, i_col} < act_cols) && ({1'b0, i_row} < act_rows);

    // walk counters, row fastest
    assign walk_c_last = occ_grid_pkg::COL_AW'(act_cols - 1'b1);
    assign walk_r_last = occ_grid_pkg::ROW_AW'(act_rows - 1'b1);
    assign lim_c    = i_ctl.init_wr ? occ_grid_pkg::COL_LAST : walk_c_last;
    assign lim_r    = i_ctl.init_wr ? occ_grid_pkg::ROW_LAST : walk_r_last;
    assign row_last = (r_wr == lim_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
            r_wr <= '0;
        end else if (i_ctl.load) begin
            r_wc <= '0;
            r_wr <= '0;
        end else if (i_ctl.init_wr || i_ctl.walk_wr) begin
            if (row_last) begin
                r_wr <= '0;
                r_wc <= r_wc + 1'b1;
            end else begin
                r_wr <= r_wr + 1'b1;
            end
        end
    end

    assign o_sts.walk_last  = row_last && (r_wc == lim_c);
    assign o_sts.grid_empty = (act_cols == '0) || (act_rows == '0);
    assign o_sts.in_clear   = (i_command == occ_grid_pkg::CMD_CLR_OBS) ||
                              (i_command == occ_grid_pkg::CMD_CLR_MOV);

    // captured command word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_command;
            r_tc     <= i_col[occ_grid_pkg::COL_AW-1:0];
            r_tr     <= i_row[occ_grid_pkg::ROW_AW-1:0];
            r_tvalid <= in_valid;
        end
    end

    assign in_addr   = {i_col[occ_grid_pkg::COL_AW-1:0], i_row[occ_grid_pkg::ROW_AW-1:0]};
    assign walk_addr = {r_wc, r_wr};
    assign tgt_addr  = {r_tc, r_tr};

    assign is_clear = (r_cmd == occ_grid_pkg::CMD_CLR_OBS) ||
                      (r_cmd == occ_grid_pkg::CMD_CLR_MOV);

    // clear rule for the grid walk
    always_comb begin
        cleared = ram_rdata;
        if (r_cmd == occ_grid_pkg::CMD_CLR_OBS) begin
            if (ram_rdata == occ_grid_pkg::CS_STATIC ||
                ram_rdata == occ_grid_pkg::CS_VIRTUAL) begin
                cleared = occ_grid_pkg::CS_FREE;
            end
        end else begin
            if (ram_rdata == occ_grid_pkg::CS_DYNAMIC) begin
                cleared = occ_grid_pkg::CS_FREE;
            end else if (ram_rdata == occ_grid_pkg::CS_BOTH) begin
                cleared = occ_grid_pkg::CS_STATIC;
            end
        end
    end

    // single-cell update rules
    always_comb begin
        nv  = ram_rdata;
        chg = 1'b0;
        case (r_cmd)
            occ_grid_pkg::CMD_DELETE: begin
                nv  = occ_grid_pkg::CS_DELETED;
                chg = 1'b1;
            end
            occ_grid_pkg::CMD_ADD, occ_grid_pkg::CMD_RM_ST: begin
                nv  = occ_grid_pkg::CS_FREE;
                chg = 1'b1;
            end
            occ_grid_pkg::CMD_ADD_ST: begin
                if (ram_rdata != occ_grid_pkg::CS_DELETED) begin
                    nv  = occ_grid_pkg::CS_STATIC;
                    chg = 1'b1;
                end
            end
            occ_grid_pkg::CMD_ADD_VIRT: begin
                if (ram_rdata == occ_grid_pkg::CS_FREE) begin
                    nv  = occ_grid_pkg::CS_VIRTUAL;
                    chg = 1'b1;
                end
            end
            occ_grid_pkg::CMD_RM_VIRT: begin
                if (ram_rdata == occ_grid_pkg::CS_VIRTUAL) begin
                    nv  = occ_grid_pkg::CS_FREE;
                    chg = 1'b1;
                end
            end
            occ_grid_pkg::CMD_ADD_MOV: begin
                if (ram_rdata != occ_grid_pkg::CS_DELETED) begin
                    nv  = (ram_rdata == occ_grid_pkg::CS_STATIC) ?
                          occ_grid_pkg::CS_BOTH : occ_grid_pkg::CS_DYNAMIC;
                    chg = 1'b1;
                end
            end
            occ_grid_pkg::CMD_RM_MOV: begin
                nv  = (ram_rdata == occ_grid_pkg::CS_BOTH) ?
                      occ_grid_pkg::CS_STATIC : occ_grid_pkg::CS_FREE;
                chg = 1'b1;
            end
            default: begin
                nv  = ram_rdata;
                chg = 1'b0;
            end
        endcase
    end

    // RAM ports
    always_comb begin
        ram_re    = i_ctl.rd_in | i_ctl.rd_walk | i_ctl.rd_tgt;
        ram_raddr = in_addr;
        if (i_ctl.rd_walk) begin
            ram_raddr = walk_addr;
        end else if (i_ctl.rd_tgt) begin
            ram_raddr = tgt_addr;
        end
        ram_we    = 1'b0;
        ram_waddr = walk_addr;
        ram_wdata = occ_grid_pkg::CS_FREE;
        if (i_ctl.init_wr) begin
            ram_we = 1'b1;
        end else if (i_ctl.walk_wr) begin
            ram_we    = 1'b1;
            ram_wdata = cleared;
        end else if (i_ctl.finish) begin
            ram_we    = r_tvalid && chg && !is_clear;
            ram_waddr = tgt_addr;
            ram_wdata = nv;
        end
    end

    occ_grid_ram #(
        .WIDTH (occ_grid_pkg::CELL_W),
        .DEPTH (occ_grid_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result
    always_comb begin
        n_version = r_version;
        n_status  = occ_grid_pkg::ST_DONE;
        n_cell    = r_tvalid ? ram_rdata : occ_grid_pkg::CS_FREE;
        if (is_clear) begin
            n_version = r_version + 1'b1;
        end else if (!r_tvalid) begin
            n_status = (r_cmd == occ_grid_pkg::CMD_ADD_MOV ||
                        r_cmd == occ_grid_pkg::CMD_RM_MOV) ?
                       occ_grid_pkg::ST_IGN : occ_grid_pkg::ST_ERR;
        end else begin
            n_cell = nv;
            if (chg) begin
                n_version = r_version + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_ctl.finish;
            if (i_ctl.finish) begin
                r_version <= n_version;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status <= n_status;
            r_cell   <= n_cell;
            r_free   <= r_tvalid && (n_cell == occ_grid_pkg::CS_FREE);
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_status;
    assign o_cell_state   = r_cell;
    assign o_is_free      = r_free;
    assign o_change_count = r_version;

endmodule

/* design/occupancy_grid_cell_engine.sv */
`timescale 1ns / 1ps
// ============================================================================
// occupancy_grid_cell_engine
// Grid of obstacle cell states with single-cell commands and full-grid clears.
// Single-cell command: RAM read in the start cycle, then modify/write in S_FIN;
//   the result strobe is registered from S_FIN; start is only taken while idle.
// Clear commands: each active cell is read (S_WRD), then written (S_WWR).
// Reset: a pass writes all 4096 cells free; busy is high meanwhile.
// Results cannot be stalled; each is shown for one cycle with o_valid.
// ============================================================================
module occupancy_grid_cell_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [occ_grid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [occ_grid_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [occ_grid_pkg::CMD_W-1:0]      i_command,
    input  logic [occ_grid_pkg::POS_W-1:0]      i_col,
    input  logic [occ_grid_pkg::POS_W-1:0]      i_row,
    output logic                                o_valid,
    output logic [occ_grid_pkg::STAT_W-1:0]     o_status,
    output logic [occ_grid_pkg::CELL_W-1:0]     o_cell_state,
    output logic                                o_is_free,
    output logic [occ_grid_pkg::VER_W-1:0]      o_change_count
);

    occ_grid_pkg::t_ctl ctl;
    occ_grid_pkg::t_sts sts;

    occ_grid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    occ_grid_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_col          (i_col),
        .i_row          (i_row),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_cell_state   (o_cell_state),
        .o_is_free      (o_is_free),
        .o_change_count (o_change_count)
    );

endmodule
